>>> src/infix_to_postfix_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter unit.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IFPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ifpc_pkg.sv
// ----------------------------------------------------------------------------
// ifpc_pkg
// Types and constants shared by the infix to postfix converter unit.
// ----------------------------------------------------------------------------
package ifpc_pkg;

    localparam int IFPC_STACK_DEPTH = 32;
    localparam int IFPC_VALUE_WIDTH = 32;
    localparam int IFPC_NUM_W       = 32;
    localparam int IFPC_Q_DEPTH     = 4;

    typedef enum logic [2:0] {
        TOK_NUMBER   = 3'd0,
        TOK_OPERATOR = 3'd1,
        TOK_OPEN     = 3'd2,
        TOK_CLOSE    = 3'd3,
        TOK_END      = 3'd4
    } t_tok_kind;

    typedef enum logic [1:0] {
        OUT_NUMBER   = 2'd0,
        OUT_OPERATOR = 2'd1,
        OUT_END_OK   = 2'd2,
        OUT_END_ERR  = 2'd3
    } t_out_kind;

    typedef struct packed {
        logic       lparen;
        logic [3:0] code;
        logic [2:0] prec;
        logic       lassoc;
    } t_stack_entry;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] code;
        logic [2:0] prec;
        logic       lassoc;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

>>> src/ifpc_token_if.sv
// ----------------------------------------------------------------------------
// ifpc_token_if
// Channel carrying one decoded infix token per beat.
// ----------------------------------------------------------------------------
interface ifpc_token_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] number_value;
    logic [3:0]         operator_code;
    logic [2:0]         precedence;
    logic               left_assoc;

    modport source (output valid, op, number_value, operator_code, precedence, left_assoc,
                    input ready);
    modport sink   (input valid, op, number_value, operator_code, precedence, left_assoc,
                    output ready);
endinterface

>>> src/ifpc_result_if.sv
// ----------------------------------------------------------------------------
// ifpc_result_if
// Channel carrying one postfix result per beat.
// ----------------------------------------------------------------------------
interface ifpc_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         out_kind;
    logic signed [31:0] out_number;
    logic [3:0]         out_operator;
    logic               last_of_run;

    modport source (output valid, out_kind, out_number, out_operator, last_of_run,
                    input ready);
    modport sink   (input valid, out_kind, out_number, out_operator, last_of_run,
                    output ready);
endinterface

>>> src/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard conversion of decoded infix tokens into postfix results.
// ----------------------------------------------------------------------------
// Tokens enter a four-beat queue, so until it fills the input keeps accepting
// while the stack engine works or the output stalls. The engine handles one
// stack step per cycle unless a result must wait for the output stage: a number
// is emitted in one step, an operator first pops each stacked operator of higher
// precedence (or equal, if it is left-associative) and is then pushed, a left
// parenthesis is pushed, a right parenthesis pops operators until it discards
// the matching parenthesis, and an end token pops every stacked entry and then
// emits the end marker. The stack top and the entry below it are held in
// registers, with the rest in an on-chip memory, so each pop takes one stack
// step. A registered output stage delivers at most one result beat per cycle.
module infix_to_postfix_converter_unit
    import ifpc_pkg::*;
#(
    parameter int STACK_DEPTH = IFPC_STACK_DEPTH,
    parameter int VALUE_WIDTH = IFPC_VALUE_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ifpc_token_if.sink    i_tok,
    ifpc_result_if.source o_res
);

    localparam int NUM_W = (VALUE_WIDTH < IFPC_NUM_W) ? VALUE_WIDTH : IFPC_NUM_W;

    t_q_head          head;
    logic [NUM_W-1:0] head_num;
    logic             head_pop;

    ifpc_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok      (i_tok),
        .o_head     (head),
        .o_head_num (head_num),
        .i_pop      (head_pop)
    );

    ifpc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_head_num (head_num),
        .o_pop      (head_pop),
        .o_res      (o_res)
    );

endmodule

>>> src/ifpc_front.sv
// ----------------------------------------------------------------------------
// ifpc_front
// Accepts token beats, drops undefined kinds and queues the rest.
// ----------------------------------------------------------------------------
module ifpc_front
    import ifpc_pkg::*;
#(
    parameter int VALUE_WIDTH = IFPC_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ifpc_token_if.sink          i_tok,
    output t_q_head             o_head,
    output logic [(VALUE_WIDTH < IFPC_NUM_W ? VALUE_WIDTH : IFPC_NUM_W)-1:0] o_head_num,
    input  logic                i_pop
);

    localparam int NUM_W = (VALUE_WIDTH < IFPC_NUM_W) ? VALUE_WIDTH : IFPC_NUM_W;
    localparam int QAW   = $clog2(IFPC_Q_DEPTH);
    localparam int QCW   = $clog2(IFPC_Q_DEPTH + 1);

    t_cmd             r_q_cmd [IFPC_Q_DEPTH];
    logic [NUM_W-1:0] r_q_num [IFPC_Q_DEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_q_cnt,  n_q_cnt;
    logic             defined;
    logic             enq;
    logic             deq;
    t_cmd             in_cmd;

    always_comb begin
        unique case (i_tok.op) inside
            TOK_NUMBER, TOK_OPERATOR, TOK_OPEN, TOK_CLOSE, TOK_END: defined = 1'b1;
            default: defined = 1'b0;
        endcase
    end

    always_comb begin
        in_cmd.kind   = t_tok_kind'(i_tok.op);
        in_cmd.code   = i_tok.operator_code;
        in_cmd.prec   = i_tok.precedence;
        in_cmd.lassoc = i_tok.left_assoc;
    end

    assign i_tok.ready = (r_q_cnt != QCW'(IFPC_Q_DEPTH));
    assign enq         = i_tok.valid && i_tok.ready && defined;
    assign deq         = i_pop && (r_q_cnt != '0);

    always_comb begin
        n_wr_ptr = enq ? QAW'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = deq ? QAW'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_q_cnt  = r_q_cnt + QCW'(enq) - QCW'(deq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_q_cnt  <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q_cmd[r_wr_ptr] <= in_cmd;
            r_q_num[r_wr_ptr] <= i_tok.number_value[NUM_W-1:0];
        end
    end

    assign o_head.valid = (r_q_cnt != '0);
    assign o_head.cmd   = r_q_cmd[r_rd_ptr];
    assign o_head_num   = r_q_num[r_rd_ptr];

endmodule

>>> src/ifpc_back.sv
// ----------------------------------------------------------------------------
// ifpc_back
// Operator stack engine: executes queued tokens and emits postfix results.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_unit_defines.svh"

module ifpc_back
    import ifpc_pkg::*;
#(
    parameter int STACK_DEPTH = IFPC_STACK_DEPTH,
    parameter int VALUE_WIDTH = IFPC_VALUE_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_head             i_head,
    input  logic [(VALUE_WIDTH < IFPC_NUM_W ? VALUE_WIDTH : IFPC_NUM_W)-1:0] i_head_num,
    output logic                o_pop,
    ifpc_result_if.source       o_res
);

    localparam int NUM_W = (VALUE_WIDTH < IFPC_NUM_W) ? VALUE_WIDTH : IFPC_NUM_W;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);

    t_stack_entry     r_mem [STACK_DEPTH];
    t_stack_entry     r_top;
    t_stack_entry     r_rd;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    n_cnt_m2;
    logic             r_err, n_err;

    logic             r_out_valid;
    t_out_kind        r_out_kind;
    logic [IFPC_NUM_W-1:0] r_out_num;
    logic [3:0]       r_out_opc;
    logic             r_out_last;

    logic             have_top;
    logic             have_below;
    logic             full;
    logic             top_cond;
    logic             rd_cond;
    logic             out_free;

    logic             do_emit;
    t_out_kind        e_kind;
    logic [NUM_W-1:0] e_num;
    logic [3:0]       e_opc;
    logic             e_last;
    logic             do_pop;
    logic             push_req;
    logic             do_push;
    t_stack_entry     push_entry;
    logic             consume;
    logic             set_err;
    logic             clr_err;

    assign have_top   = (r_count != '0);
    assign have_below = (r_count > CW'(1));
    assign full       = (r_count == CW'(STACK_DEPTH));
    assign out_free   = !r_out_valid || o_res.ready;

    assign top_cond = !r_top.lparen && ((r_top.prec > i_head.cmd.prec) ||
                      ((r_top.prec == i_head.cmd.prec) && i_head.cmd.lassoc));
    assign rd_cond  = !r_rd.lparen && ((r_rd.prec > i_head.cmd.prec) ||
                      ((r_rd.prec == i_head.cmd.prec) && i_head.cmd.lassoc));

    always_comb begin
        do_emit    = 1'b0;
        e_kind     = OUT_NUMBER;
        e_num      = '0;
        e_opc      = '0;
        e_last     = 1'b0;
        do_pop     = 1'b0;
        push_req   = 1'b0;
        push_entry = '0;
        consume    = 1'b0;
        set_err    = 1'b0;
        clr_err    = 1'b0;
        if (i_head.valid) begin
            unique case (i_head.cmd.kind)
                TOK_NUMBER: begin
                    do_emit = 1'b1;
                    e_kind  = OUT_NUMBER;
                    e_num   = i_head_num;
                    e_last  = 1'b1;
                    consume = out_free;
                end
                TOK_OPERATOR: begin
                    if (have_top && top_cond) begin
                        do_emit = 1'b1;
                        e_kind  = OUT_OPERATOR;
                        e_opc   = r_top.code;
                        e_last  = !(have_below && rd_cond);
                        do_pop  = out_free;
                    end else begin
                        push_req          = 1'b1;
                        push_entry.code   = i_head.cmd.code;
                        push_entry.prec   = i_head.cmd.prec;
                        push_entry.lassoc = i_head.cmd.lassoc;
                        consume           = 1'b1;
                    end
                end
                TOK_OPEN: begin
                    push_req          = 1'b1;
                    push_entry.lparen = 1'b1;
                    consume           = 1'b1;
                end
                TOK_CLOSE: begin
                    if (!have_top) begin
                        set_err = 1'b1;
                        consume = 1'b1;
                    end else if (r_top.lparen) begin
                        do_pop  = 1'b1;
                        consume = 1'b1;
                    end else begin
                        do_emit = 1'b1;
                        e_kind  = OUT_OPERATOR;
                        e_opc   = r_top.code;
                        e_last  = !have_below || r_rd.lparen;
                        do_pop  = out_free;
                    end
                end
                TOK_END: begin
                    if (!have_top) begin
                        do_emit = 1'b1;
                        e_kind  = r_err ? OUT_END_ERR : OUT_END_OK;
                        e_last  = 1'b1;
                        consume = out_free;
                        clr_err = out_free;
                    end else if (r_top.lparen) begin
                        do_pop  = 1'b1;
                        set_err = 1'b1;
                    end else begin
                        do_emit = 1'b1;
                        e_kind  = OUT_OPERATOR;
                        e_opc   = r_top.code;
                        e_last  = 1'b0;
                        do_pop  = out_free;
                    end
                end
                default: begin
                    consume = 1'b1;
                end
            endcase
        end
    end

    assign do_push = push_req && !full;
    assign o_pop   = consume;

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CW'(1);
        end else if (do_pop) begin
            n_count = r_count - CW'(1);
        end
        n_cnt_m2 = n_count - CW'(2);
        n_err = r_err;
        if (clr_err) begin
            n_err = 1'b0;
        end else if (set_err || (push_req && full)) begin
            n_err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push && have_top) begin
            r_mem[AW'(r_count - CW'(1))] <= r_top;
        end
        if (do_push) begin
            r_rd <= r_top;
        end else begin
            r_rd <= r_mem[n_cnt_m2[AW-1:0]];
        end
        if (do_push) begin
            r_top <= push_entry;
        end else if (do_pop) begin
            r_top <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= do_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit && out_free) begin
            r_out_kind <= e_kind;
            r_out_num  <= IFPC_NUM_W'(e_num);
            r_out_opc  <= e_opc;
            r_out_last <= e_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_kind     = r_out_kind;
    assign o_res.out_number   = r_out_num;
    assign o_res.out_operator = r_out_opc;
    assign o_res.last_of_run  = r_out_last;

    `IFPC_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH), "stack count above depth")
    `IFPC_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, do_pop, have_top, "pop from an empty stack")
    `IFPC_ASSERT_NEXT(a_drop_err, i_clk, i_rst_n, push_req && full, r_err, "dropped push did not latch error")
    `IFPC_ASSERT_NEXT(a_end_clean, i_clk, i_rst_n, clr_err, (r_count == '0) && !r_err, "state not clean after end marker")

endmodule

>>> bench/tb_infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_unit
// Self-checking bench for the shunting-yard infix to postfix converter.
// A directed token table is replayed first, covering value extremes, every
// token kind, parenthesis errors, stack overflow and error clearing. It is
// followed by random expressions, deep nesting, long right-associative chains
// and noise. Every result beat is compared with a shadow operator stack,
// under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter_unit;
    import ifpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIR        = 32;
    localparam int N_RANDOM     = 264;
    localparam int PAUSE_AT     = 60;
    localparam int QUIET_LO     = 100;
    localparam int QUIET_HI     = 180;
    localparam int HOLD_AT      = 220;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 22;

    localparam logic [2:0] TOK_RSVD5 = 3'd5;
    localparam logic [2:0] TOK_RSVD7 = 3'd7;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [3:0]         code;
        logic [2:0]         prec;
        logic               lassoc;
        bit                 fixed;
        t_out_kind          fixed_kind;
        logic signed [31:0] fixed_number;
        int                 reps;
    } t_tok_item;

    typedef struct {
        t_out_kind          kind;
        logic signed [31:0] number;
        logic [3:0]         opcode;
        logic               last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    ifpc_token_if  tok_if ();
    ifpc_result_if res_if ();

    infix_to_postfix_converter_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    t_stack_entry shadow_stack [IFPC_STACK_DEPTH];
    int           shadow_depth;
    bit           shadow_err;
    t_result      beat_run [$];
    t_result      postfix_expected [$];

    t_tok_item    dir_rows [N_DIR];
    t_tok_item    tok_seq [$];
    t_tok_item    tok_cur;
    int           n_scheduled;
    int           n_fail;
    int           stall_cycles;
    bit           quiet;
    bit           hold_req;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void emit_result(t_out_kind kind, logic signed [31:0] number,
                                        logic [3:0] opcode);
        t_result r;
        r.kind   = kind;
        r.number = number;
        r.opcode = opcode;
        r.last   = 1'b0;
        beat_run.push_back(r);
    endfunction

    function automatic void pop_operator();
        shadow_depth--;
        emit_result(OUT_OPERATOR, '0, shadow_stack[shadow_depth].code);
    endfunction

    function automatic void push_entry(t_stack_entry e);
        if (shadow_depth >= IFPC_STACK_DEPTH) begin
            shadow_err = 1'b1;
        end else begin
            shadow_stack[shadow_depth] = e;
            shadow_depth++;
        end
    endfunction

    function automatic void shunt_token(t_tok_item t);
        t_stack_entry top;
        bit           matched;
        beat_run.delete();
        case (t.kind)
            TOK_NUMBER: begin
                emit_result(OUT_NUMBER, t.value, '0);
            end
            TOK_OPERATOR: begin
                while (shadow_depth > 0) begin
                    top = shadow_stack[shadow_depth - 1];
                    if (top.lparen) break;
                    if (top.prec > t.prec || (top.prec == t.prec && t.lassoc)) begin
                        pop_operator();
                    end else begin
                        break;
                    end
                end
                push_entry('{lparen: 1'b0, code: t.code, prec: t.prec, lassoc: t.lassoc});
            end
            TOK_OPEN: begin
                push_entry('{lparen: 1'b1, code: 4'd0, prec: 3'd0, lassoc: 1'b0});
            end
            TOK_CLOSE: begin
                matched = 1'b0;
                while (shadow_depth > 0) begin
                    if (shadow_stack[shadow_depth - 1].lparen) begin
                        shadow_depth--;
                        matched = 1'b1;
                        break;
                    end
                    pop_operator();
                end
                if (!matched) shadow_err = 1'b1;
            end
            TOK_END: begin
                while (shadow_depth > 0) begin
                    if (shadow_stack[shadow_depth - 1].lparen) begin
                        shadow_depth--;
                        shadow_err = 1'b1;
                    end else begin
                        pop_operator();
                    end
                end
                emit_result(shadow_err ? OUT_END_ERR : OUT_END_OK, '0, '0);
                shadow_err = 1'b0;
            end
            default: begin
            end
        endcase
        if (beat_run.size() > 0) begin
            if (t.fixed) begin
                beat_run[beat_run.size() - 1].kind   = t.fixed_kind;
                beat_run[beat_run.size() - 1].number = t.fixed_number;
            end
            beat_run[beat_run.size() - 1].last = 1'b1;
            foreach (beat_run[i]) postfix_expected.push_back(beat_run[i]);
        end
    endfunction

    function automatic void add_token(logic [2:0] kind);
        t_tok_item t;
        t.kind         = kind;
        t.value        = $urandom;
        t.code         = 4'($urandom_range(15));
        t.prec         = 3'($urandom_range(7));
        t.lassoc       = 1'($urandom_range(1));
        t.fixed        = 1'b0;
        t.fixed_kind   = OUT_NUMBER;
        t.fixed_number = '0;
        t.reps         = 1;
        tok_seq.push_back(t);
        n_scheduled++;
    endfunction

    function automatic void gen_expr(int depth);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0) add_token(TOK_OPERATOR);
            if (depth > 0 && $urandom_range(3) == 0) begin
                add_token(TOK_OPEN);
                gen_expr(depth - 1);
                add_token(TOK_CLOSE);
            end else begin
                add_token(TOK_NUMBER);
            end
        end
    endfunction

    function automatic void build_stimulus();
        int         mode;
        int         k;
        logic [2:0] p;
        while (n_scheduled < N_RANDOM) begin
            mode = $urandom_range(99);
            if (mode < 70) begin
                gen_expr(3);
            end else if (mode < 80) begin
                k = $urandom_range(20, 36);
                repeat (k) add_token(TOK_OPEN);
                add_token(TOK_NUMBER);
                repeat ($urandom_range(k - 2, k + 1)) add_token(TOK_CLOSE);
            end else if (mode < 88) begin
                k = $urandom_range(20, 36);
                p = 3'($urandom_range(7));
                add_token(TOK_NUMBER);
                repeat (k) begin
                    add_token(TOK_OPERATOR);
                    tok_seq[tok_seq.size() - 1].prec   = p;
                    tok_seq[tok_seq.size() - 1].lassoc = 1'b0;
                    add_token(TOK_NUMBER);
                end
            end else begin
                repeat ($urandom_range(1, 8)) add_token(3'($urandom_range(7)));
            end
            add_token(TOK_END);
        end
    endfunction

    task automatic send_token(t_tok_item t);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            tok_if.valid = 1'b0;
            @(negedge i_clk);
        end
        tok_cur              = t;
        tok_if.op            = t.kind;
        tok_if.number_value  = t.value;
        tok_if.operator_code = t.code;
        tok_if.precedence    = t.prec;
        tok_if.left_assoc    = t.lassoc;
        tok_if.valid         = 1'b1;
        do @(posedge i_clk); while (!tok_if.ready);
    endtask

    task automatic wait_drained();
        while (postfix_expected.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req     = 1'b0;
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_if.ready = quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (tok_if.valid && tok_if.ready) begin
                shunt_token(tok_cur);
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                if (postfix_expected.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected beat kind %0d number %0d operator %0d last %0d",
                             $time, res_if.out_kind, res_if.out_number,
                             res_if.out_operator, res_if.last_of_run);
                end else begin
                    want = postfix_expected.pop_front();
                    if (res_if.out_kind !== want.kind || res_if.out_number !== want.number ||
                        res_if.out_operator !== want.opcode ||
                        res_if.last_of_run !== want.last) begin
                        n_fail++;
                        $display("%0t: mismatch expected kind %0d number %0d operator %0d last %0d",
                                 $time, want.kind, want.number, want.opcode, want.last);
                        $display("%0t:          actual   kind %0d number %0d operator %0d last %0d",
                                 $time, res_if.out_kind, res_if.out_number,
                                 res_if.out_operator, res_if.last_of_run);
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("** infix_to_postfix_converter_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        tok_if.valid         = 1'b0;
        tok_if.op            = TOK_NUMBER;
        tok_if.number_value  = '0;
        tok_if.operator_code = '0;
        tok_if.precedence    = '0;
        tok_if.left_assoc    = 1'b0;
        quiet                = 1'b0;
        hold_req             = 1'b0;
        n_fail               = 0;
        n_scheduled          = 0;
        stall_cycles         = 0;
        shadow_depth         = 0;
        shadow_err           = 1'b0;

        dir_rows = '{
            '{TOK_NUMBER,   32'sh0000_0000, 4'd0,  3'd0, 1'b0, 1'b1, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sh7FFF_FFFF, 4'd0,  3'd0, 1'b0, 1'b1, OUT_NUMBER,  32'sh7FFF_FFFF, 1},
            '{TOK_NUMBER,   32'sh8000_0000, 4'd0,  3'd0, 1'b0, 1'b1, OUT_NUMBER,  32'sh8000_0000, 1},
            '{TOK_NUMBER,   32'shFFFF_FFFF, 4'd15, 3'd7, 1'b1, 1'b1, OUT_NUMBER,  32'shFFFF_FFFF, 1},
            '{TOK_END,      32'shFFFF_FFFF, 4'd15, 3'd7, 1'b1, 1'b1, OUT_END_OK,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd7,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd0,  3'd0, 1'b1, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd8,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd15, 3'd7, 1'b1, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd9,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd3,  3'd0, 1'b1, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd10,        4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd5,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPEN,     32'sd0,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd11,        4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd9,  3'd4, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd12,        4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_CLOSE,    32'sd0,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_RSVD5,    32'shFFFF_FFFF, 4'd15, 3'd7, 1'b1, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_RSVD7,    32'shFFFF_FFFF, 4'd15, 3'd7, 1'b1, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_END,      32'sd0,         4'd0,  3'd0, 1'b0, 1'b1, OUT_END_OK,  32'sh0000_0000, 1},
            '{TOK_NUMBER,   32'sd1,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd2,  3'd3, 1'b1, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_CLOSE,    32'sd0,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_END,      32'sd0,         4'd0,  3'd0, 1'b0, 1'b1, OUT_END_ERR, 32'sh0000_0000, 1},
            '{TOK_OPEN,     32'sd0,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 1},
            '{TOK_END,      32'sd0,         4'd0,  3'd0, 1'b0, 1'b1, OUT_END_ERR, 32'sh0000_0000, 1},
            '{TOK_OPEN,     32'sd0,         4'd0,  3'd0, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 33},
            '{TOK_END,      32'sd0,         4'd0,  3'd0, 1'b0, 1'b1, OUT_END_ERR, 32'sh0000_0000, 1},
            '{TOK_OPERATOR, 32'sd0,         4'd6,  3'd2, 1'b0, 1'b0, OUT_NUMBER,  32'sh0000_0000, 33},
            '{TOK_END,      32'sd0,         4'd0,  3'd0, 1'b0, 1'b1, OUT_END_ERR, 32'sh0000_0000, 1},
            '{TOK_END,      32'sd0,         4'd0,  3'd0, 1'b0, 1'b1, OUT_END_OK,  32'sh0000_0000, 1}
        };
        build_stimulus();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].reps) send_token(dir_rows[i]);
        end

        foreach (tok_seq[i]) begin
            if (i == PAUSE_AT) begin
                @(negedge i_clk);
                tok_if.valid = 1'b0;
                wait_drained();
            end
            quiet = (i >= QUIET_LO && i < QUIET_HI);
            if (i == HOLD_AT) hold_req = 1'b1;
            send_token(tok_seq[i]);
        end
        @(negedge i_clk);
        tok_if.valid = 1'b0;
        quiet        = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && postfix_expected.size() == 0) begin
            $display("** infix_to_postfix_converter_unit: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/ifpc_pkg.sv
src/ifpc_token_if.sv
src/ifpc_result_if.sv
src/ifpc_front.sv
src/ifpc_back.sv
src/infix_to_postfix_converter_unit.sv
bench/tb_infix_to_postfix_converter_unit.sv
